/* rtl/efrc_pkg.sv */
// Shared types and constants for the escaped frame receiver with checksum.
// No dependencies; imported by every module of the block.
`default_nettype none

package efrc_pkg;

	// Longest frame, in slots, before the frame is marked garbage
	localparam logic [8:0] MAX_FRAME = 9'd255;

	// Mark bit in a delay-line entry for the separator slot
	localparam logic [8:0] SEP_MARK = 9'h100;

	// Configuration register indexes
	localparam logic [1:0] REG_START     = 2'd0;
	localparam logic [1:0] REG_SEPARATOR = 2'd1;
	localparam logic [1:0] REG_END       = 2'd2;
	localparam logic [1:0] REG_ESCAPE    = 2'd3;

	// Reset values of the control codes
	localparam logic [7:0] RST_START     = 8'd1;
	localparam logic [7:0] RST_SEPARATOR = 8'd2;
	localparam logic [7:0] RST_END       = 8'd4;
	localparam logic [7:0] RST_ESCAPE    = 8'd27;

	typedef enum logic [2:0] {
		VERD_GOOD      = 3'd0,
		VERD_GARBAGE   = 3'd1,
		VERD_NO_HEADER = 3'd2,
		VERD_SHORT     = 3'd3,
		VERD_MISMATCH  = 3'd4
	} verdict_t;

	typedef enum logic {
		KIND_BYTE    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] separator_code;
		logic [7:0] end_code;
		logic [7:0] escape_code;
	} codes_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
		logic [8:0] position;
		logic       in_body;
		verdict_t   verdict;
		logic [8:0] header_length;
		logic [8:0] body_length;
	} result_t;

endpackage

`default_nettype wire

/* rtl/efrc_cfg_regs.sv */
// Control code registers written through the plain configuration port.
// Depends on efrc_pkg for register indexes, reset values and codes_t.
`default_nettype none

module efrc_cfg_regs
	import efrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output codes_t          codes
);

	codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code     <= RST_START;
			codes_q.separator_code <= RST_SEPARATOR;
			codes_q.end_code       <= RST_END;
			codes_q.escape_code    <= RST_ESCAPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:     codes_q.start_code     <= cfg_data;
				REG_SEPARATOR: codes_q.separator_code <= cfg_data;
				REG_END:       codes_q.end_code       <= cfg_data;
				REG_ESCAPE:    codes_q.escape_code    <= cfg_data;
				default:       codes_q.start_code     <= codes_q.start_code;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

`default_nettype wire

/* rtl/efrc_frame.sv */
// Frame state, control code decode and lagging mod-256 sum and sum of sums for one byte.
// Depends on efrc_pkg for codes_t, result_t and the frame constants.
`default_nettype none

module efrc_frame
	import efrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire codes_t     codes,
	input  wire logic [7:0] rx_byte,
	input  wire logic       step,
	output result_t         res,
	output logic            res_valid
);

	logic [8:0] fill_q, sep_q, lag0_q, lag1_q;
	logic       garb_q, esc_q;
	logic [7:0] ss_q, sf_q;
	logic [1:0] lc_q;

	logic [8:0] fill_n, sep_n, lag0_n, lag1_n;
	logic       garb_n, esc_n;
	logic [7:0] ss_n, sf_n;
	logic [1:0] lc_n;

	logic       push;
	logic [8:0] entry;

	always_comb begin
		fill_n    = fill_q;
		sep_n     = sep_q;
		garb_n    = garb_q;
		esc_n     = esc_q;
		ss_n      = ss_q;
		sf_n      = sf_q;
		lag0_n    = lag0_q;
		lag1_n    = lag1_q;
		lc_n      = lc_q;
		res       = '0;
		res_valid = 1'b0;
		push      = 1'b0;
		entry     = '0;

		// Overlong frame: drop contents, keep garbage until the next start
		if (fill_q > MAX_FRAME) begin
			garb_n = 1'b1;
			fill_n = '0;
			ss_n   = '0;
			sf_n   = '0;
			lag0_n = '0;
			lag1_n = '0;
			lc_n   = '0;
		end

		priority if (!esc_q && rx_byte == codes.start_code) begin
			fill_n = '0;
			ss_n   = '0;
			sf_n   = '0;
			lag0_n = '0;
			lag1_n = '0;
			lc_n   = '0;
			sep_n  = '0;
			garb_n = 1'b0;
		end else if (!esc_q && rx_byte == codes.separator_code) begin
			if (sep_q != '0)
				garb_n = 1'b1;
			sep_n = fill_n;
			push  = 1'b1;
			entry = SEP_MARK;
		end else if (!esc_q && rx_byte == codes.end_code) begin
			res_valid         = 1'b1;
			res.kind          = KIND_VERDICT;
			res.header_length = sep_q;
			if (garb_n)
				res.verdict = VERD_GARBAGE;
			else if (sep_q == '0)
				res.verdict = VERD_NO_HEADER;
			else if ({1'b0, fill_n} < ({1'b0, sep_q} + 10'd3))
				res.verdict = VERD_SHORT;
			else if (lag1_n == {1'b0, ss_n} && lag0_n == {1'b0, sf_n})
				res.verdict = VERD_GOOD;
			else
				res.verdict = VERD_MISMATCH;
			if (res.verdict == VERD_GOOD)
				res.body_length = fill_n - sep_q - 9'd3;
		end else if (!esc_q && rx_byte == codes.escape_code) begin
			esc_n = 1'b1;
		end else begin
			esc_n          = 1'b0;
			res_valid      = 1'b1;
			res.kind       = KIND_BYTE;
			res.byte_value = rx_byte;
			res.position   = fill_n;
			res.in_body    = (sep_q != '0) && (fill_n > sep_q);
			push           = 1'b1;
			entry          = {1'b0, rx_byte};
		end

		// Two-slot delay line; the oldest slot enters the sums as it leaves, unless it is the separator
		if (push) begin
			if (lc_n[1]) begin
				if (!lag0_n[8]) begin
					ss_n = ss_n + lag0_n[7:0];
					sf_n = sf_n + ss_n;
				end
				lag0_n = lag1_n;
				lag1_n = entry;
			end else begin
				if (lc_n == 2'd0)
					lag0_n = entry;
				else
					lag1_n = entry;
				lc_n = lc_n + 2'd1;
			end
			fill_n = fill_n + 9'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sep_q  <= '0;
			garb_q <= 1'b0;
			esc_q  <= 1'b0;
			ss_q   <= '0;
			sf_q   <= '0;
			lag0_q <= '0;
			lag1_q <= '0;
			lc_q   <= '0;
		end else if (step) begin
			fill_q <= fill_n;
			sep_q  <= sep_n;
			garb_q <= garb_n;
			esc_q  <= esc_n;
			ss_q   <= ss_n;
			sf_q   <= sf_n;
			lag0_q <= lag0_n;
			lag1_q <= lag1_n;
			lc_q   <= lc_n;
		end
	end

	a_lag_count: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q != 2'd3)
		else $error("delay line count past two");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_FRAME + 9'd1)
		else $error("fill count beyond one past the frame limit");

	a_sep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sep_q <= MAX_FRAME)
		else $error("separator slot beyond the frame limit");

endmodule

`default_nettype wire

/* rtl/escaped_frame_receiver_checksum.sv */
// A byte transferred on the slave side passes the input register and the frame
// logic into the result register, which drives m_tvalid on the master side.
// Throughput: one byte per cycle unless a result held on the master side stalls it.
// Reset (arst_n low, asynchronous): frame state cleared, control codes back to
// start 1, separator 2, end 4, escape 27; both pipeline registers empty.
// Depends on efrc_pkg, efrc_cfg_regs and efrc_frame.
`default_nettype none

module escaped_frame_receiver_checksum
	import efrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Received bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] byte_value, [16:8] position, [17] in_body, [20:18] verdict,
	// [29:21] header_length, [38:30] body_length, [39] zero
	output logic [39:0]      m_tdata,
	output logic             m_tuser    // [0] kind
);

	codes_t     codes;
	result_t    res;
	logic       res_valid;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register
	logic       out_valid_q;
	result_t    out_res_q;

	logic       out_free;
	logic       advance;

	efrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	efrc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.codes     (codes),
		.rx_byte   (byte_s1),
		.step      (advance),
		.res       (res),
		.res_valid (res_valid)
	);

	// The result register frees up when empty or when its transfer completes
	assign out_free = !out_valid_q || m_tready;

	// Move the held byte through the frame logic; bytes that give no result (start,
	// separator and escape codes) never wait on the master side
	assign advance  = valid_s1 && (!res_valid || out_free);

	// Take a new byte when the input register is empty or drains this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_res_q.kind;
	assign m_tdata  = {1'b0,
	                   out_res_q.body_length,
	                   out_res_q.header_length,
	                   out_res_q.verdict,
	                   out_res_q.in_body,
	                   out_res_q.position,
	                   out_res_q.byte_value};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.kind == KIND_VERDICT) |->
		(out_res_q.byte_value == '0 && out_res_q.position == '0 && !out_res_q.in_body))
		else $error("verdict carries byte fields");

	a_body_good: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_res_q.body_length != '0) |->
		(out_res_q.kind == KIND_VERDICT && out_res_q.verdict == VERD_GOOD))
		else $error("body length given without a good verdict");

endmodule

`default_nettype wire

/* tb/escaped_frame_receiver_checksum_tb.sv */
// Self-checking testbench for escaped_frame_receiver_checksum: random and directed
// byte streams are deframed by a local predictor and compared with the block's results.
// Depends on efrc_pkg and the escaped_frame_receiver_checksum RTL.
`timescale 1ns / 1ps

module escaped_frame_receiver_checksum_tb;
	import efrc_pkg::*;

	// Ways to spoil a generated frame so that every verdict is reached
	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_SUM,
		FLAW_NO_SEP,
		FLAW_SECOND_SEP,
		FLAW_SHORT,
		FLAW_REJUDGE,
		FLAW_TRUNCATE
	} flaw_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_START;
	logic [7:0]  cfg_data  = 8'h00;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;             // byte, position, in_body, verdict, header, body
	logic        m_tuser;             // [0] kind

	escaped_frame_receiver_checksum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// Bytes waiting to go out on the line, and the stored bytes / verdicts they must produce
	logic [7:0] line_bytes_q[$];
	result_t    due_events_q[$];
	int         bytes_queued   = 0;
	int         bytes_accepted = 0;
	int         events_seen    = 0;
	int         mismatches     = 0;

	// Local copy of the control codes, updated whenever the block's registers are written
	logic [7:0] code_start, code_sep, code_end, code_esc;

	// Deframer state mirrored from the block
	logic [8:0] slots_filled;
	logic [8:0] sep_at;
	logic       frame_bad;
	logic       esc_armed;
	logic [7:0] sum_a;        // slow (plain) sum
	logic [7:0] sum_b;        // fast (sum of sums)
	logic [8:0] lag_slot[2];  // two-slot delay line feeding the sums; bit 8 marks the separator
	logic [1:0] lag_n;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("tb: mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic void clear_frame();
		slots_filled = '0;
		sum_a        = '0;
		sum_b        = '0;
		lag_slot[0]  = '0;
		lag_slot[1]  = '0;
		lag_n        = '0;
	endfunction

	// Put one slot into the frame; the slot leaving the delay line enters the sums unless it is the separator
	function automatic void push_slot(input logic [8:0] entry);
		if (lag_n >= 2) begin
			if (!lag_slot[0][8]) begin
				sum_a = sum_a + lag_slot[0][7:0];
				sum_b = sum_b + sum_a;
			end
			lag_slot[0] = lag_slot[1];
			lag_slot[1] = entry;
		end else begin
			lag_slot[lag_n] = entry;
			lag_n           = lag_n + 2'd1;
		end
		slots_filled = slots_filled + 9'd1;
	endfunction

	// Advance the deframer by one received byte and queue what the block must report
	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		// An overlong frame turns to garbage before the byte is looked at
		if (slots_filled > MAX_FRAME) begin
			frame_bad = 1'b1;
			clear_frame();
		end
		// Priority among equal codes: start, then separator, then end, then escape
		if (!esc_armed && b == code_start) begin
			clear_frame();
			sep_at    = '0;
			frame_bad = 1'b0;
		end else if (!esc_armed && b == code_sep) begin
			if (sep_at != 0)
				frame_bad = 1'b1;
			sep_at = slots_filled;
			push_slot(SEP_MARK);
		end else if (!esc_armed && b == code_end) begin
			r.kind          = KIND_VERDICT;
			r.header_length = sep_at;
			if (frame_bad)
				r.verdict = VERD_GARBAGE;
			else if (sep_at == 0)
				r.verdict = VERD_NO_HEADER;
			else if (slots_filled < sep_at + 3)
				r.verdict = VERD_SHORT;
			else if (lag_slot[1] == {1'b0, sum_a} && lag_slot[0] == {1'b0, sum_b}) begin
				r.verdict     = VERD_GOOD;
				r.body_length = slots_filled - sep_at - 9'd3;
			end else
				r.verdict = VERD_MISMATCH;
			due_events_q.push_back(r);
		end else if (!esc_armed && b == code_esc) begin
			esc_armed = 1'b1;
		end else begin
			esc_armed    = 1'b0;
			r.kind       = KIND_BYTE;
			r.byte_value = b;
			r.position   = slots_filled;
			r.in_body    = (sep_at != 0) && (slots_filled > sep_at);
			push_slot({1'b0, b});
			due_events_q.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("event %0d %s: got %0d, want %0d",
				events_seen, name, got, want));
	endtask

	// Compare one result transfer with the oldest outstanding expectation
	task automatic compare_event(input logic kind_bit, input logic [39:0] d);
		result_t e;
		if (due_events_q.size() == 0) begin
			report_mismatch($sformatf("event %0d arrived with nothing due: kind %0b data %h",
				events_seen, kind_bit, d));
		end else begin
			e = due_events_q.pop_front();
			check_field("kind",          kind_bit,   e.kind);
			check_field("byte_value",    d[7:0],     e.byte_value);
			check_field("position",      d[16:8],    e.position);
			check_field("in_body",       d[17],      e.in_body);
			check_field("verdict",       d[20:18],   e.verdict);
			check_field("header_length", d[29:21],   e.header_length);
			check_field("body_length",   d[38:30],   e.body_length);
		end
		events_seen++;
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps; gaps of zero merge bursts
	// into long stretches at full rate.
	// ------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= 8'h00;
			burst_left = 1;
			gap_left   = 0;
		end else begin
			// A transfer happened at this edge: predict from the byte that went in
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				bytes_accepted++;
			end
			// Hold the current byte until it transfers, then advance
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (line_bytes_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= line_bytes_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(24, 1);
						gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: the stall mode is drawn anew each time the mode counter wraps,
	// among always ready, frequent short stalls and rare long ones.
	// ------------------------------------------------------------------
	int stall_left  = 0;
	int stall_mode  = 0;
	int mode_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_left  = 0;
			stall_mode  = 0;
			mode_cycles = 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_event(m_tuser, m_tdata);
			mode_cycles++;
			if (mode_cycles == 128) begin
				mode_cycles = 0;
				stall_mode  = $urandom_range(2, 0);
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (stall_mode == 1 && $urandom_range(3, 0) == 0)
					stall_left = $urandom_range(2, 1);
				else if (stall_mode == 2 && $urandom_range(7, 0) == 0)
					stall_left = $urandom_range(12, 4);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] b);
		line_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	// Send a data byte, escaping it if it collides with any control code
	task automatic queue_data(input logic [7:0] b);
		if (b == code_start || b == code_sep || b == code_end || b == code_esc)
			queue_byte(code_esc);
		queue_byte(b);
	endtask

	// Build one frame with random content and a correct checksum unless spoiled
	task automatic add_frame(input int hdr_n, input int body_n, input flaw_e flaw);
		logic [7:0] s_slow, s_fast, b;
		int         k, n_check;
		s_slow = '0;
		s_fast = '0;
		queue_byte(code_start);
		for (k = 0; k < hdr_n; k++) begin
			b = 8'($urandom);
			queue_data(b);
			s_slow = s_slow + b;
			s_fast = s_fast + s_slow;
		end
		if (flaw != FLAW_NO_SEP)
			queue_byte(code_sep);
		if (flaw == FLAW_SHORT)
			body_n = 0;
		for (k = 0; k < body_n; k++) begin
			b = 8'($urandom);
			queue_data(b);
			s_slow = s_slow + b;
			s_fast = s_fast + s_slow;
		end
		if (flaw == FLAW_SECOND_SEP)
			queue_byte(code_sep);
		if (flaw == FLAW_BAD_SUM)
			s_fast = s_fast ^ (8'h01 << $urandom_range(7, 0));
		// Check bytes: fast sum first, slow sum last
		n_check = (flaw == FLAW_SHORT) ? $urandom_range(1, 0) : 2;
		if (n_check == 2)
			queue_data(s_fast);
		if (n_check >= 1)
			queue_data(s_slow);
		if (flaw == FLAW_TRUNCATE)
			return;
		queue_byte(code_end);
		// Append after the verdict and judge the whole frame again
		if (flaw == FLAW_REJUDGE) begin
			queue_data(8'($urandom));
			queue_byte(code_end);
		end
	endtask

	// Mostly well-formed frames, some spoiled, some line noise between them
	task automatic random_phase(input int n_items, input bit with_overlong);
		int goal, pick, hdr_n;
		goal = bytes_queued + n_items;
		if (with_overlong)
			add_frame(200, 60, FLAW_NONE);
		while (bytes_queued < goal) begin
			pick = $urandom_range(9, 0);
			if (pick == 0) begin
				repeat ($urandom_range(6, 1)) queue_byte(8'($urandom));
			end else begin
				hdr_n = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(6, 1);
				pick  = $urandom_range(11, 0);
				add_frame(hdr_n, $urandom_range(12, 0),
					(pick < 6) ? FLAW_NONE : flaw_e'(pick - 5));
			end
		end
	endtask

	// Wait until every queued byte has transferred and every result has come back,
	// then let the pipeline settle in case the last bytes produce nothing
	task automatic wait_idle();
		int spent;
		spent = 0;
		while ((bytes_accepted != bytes_queued || due_events_q.size() != 0) && spent < 100000) begin
			@(posedge clk);
			spent++;
		end
		if (spent >= 100000)
			report_mismatch("results stopped arriving");
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic set_codes(input logic [7:0] st, input logic [7:0] sp,
	                         input logic [7:0] en, input logic [7:0] es);
		write_reg(REG_START, st);
		write_reg(REG_SEPARATOR, sp);
		write_reg(REG_END, en);
		write_reg(REG_ESCAPE, es);
		@(posedge clk);
		cfg_we     <= 1'b0;
		code_start = st;
		code_sep   = sp;
		code_end   = en;
		code_esc   = es;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] ra, rb, rc, rd;
		code_start = RST_START;
		code_sep   = RST_SEPARATOR;
		code_end   = RST_END;
		code_esc   = RST_ESCAPE;
		sep_at     = '0;
		frame_bad  = 1'b0;
		esc_armed  = 1'b0;
		clear_frame();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: codes at their reset values
		queue_byte(RST_END);                             // verdict with no frame at all
		queue_byte(8'h00);
		queue_byte(8'hFF);                               // data extremes outside a frame
		queue_byte(RST_START);
		queue_byte(RST_ESCAPE); queue_byte(RST_START);   // escaped start is data
		queue_byte(RST_ESCAPE); queue_byte(RST_ESCAPE);  // escaped escape is data
		queue_byte(RST_ESCAPE); queue_byte(8'h80);       // escape before a plain byte
		queue_byte(RST_SEPARATOR);
		queue_byte(RST_ESCAPE); queue_byte(RST_END);
		queue_byte(RST_ESCAPE); queue_byte(RST_SEPARATOR);
		queue_byte(RST_END);                             // verdict on a wrong checksum
		queue_byte(RST_SEPARATOR);                       // second separator: garbage
		queue_byte(RST_END);
		queue_byte(RST_START);
		queue_byte(RST_SEPARATOR);                       // empty header
		queue_byte(RST_END);
		add_frame(2, 1, FLAW_NONE);
		wait_idle();

		random_phase(150, 1'b0);
		wait_idle();

		// Extremes of the code values, plus one frame that runs past the limit
		set_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
		random_phase(400, 1'b1);
		wait_idle();

		set_codes(8'hFF, 8'h00, 8'hFE, 8'h01);
		random_phase(200, 1'b0);
		wait_idle();

		// End shares its value with escape, so escaping is shadowed by end
		set_codes(8'h7E, 8'h7D, 8'h7C, 8'h7C);
		random_phase(120, 1'b0);
		wait_idle();

		// All codes equal: start wins everywhere
		set_codes(8'h55, 8'h55, 8'h55, 8'h55);
		random_phase(40, 1'b0);
		wait_idle();

		do begin
			ra = 8'($urandom);
			rb = 8'($urandom);
			rc = 8'($urandom);
			rd = 8'($urandom);
		end while (ra == rb || ra == rc || ra == rd || rb == rc || rb == rd || rc == rd);
		set_codes(ra, rb, rc, rd);
		random_phase(200, 1'b0);
		wait_idle();

		set_codes(RST_START, RST_SEPARATOR, RST_END, RST_ESCAPE);
		random_phase(200, 1'b0);
		wait_idle();

		repeat (20) @(posedge clk);
		if (due_events_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", due_events_q.size()));
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* escaped_frame_receiver_checksum.f */
rtl/efrc_pkg.sv
rtl/efrc_cfg_regs.sv
rtl/efrc_frame.sv
rtl/escaped_frame_receiver_checksum.sv
tb/escaped_frame_receiver_checksum_tb.sv
